### hdl/bmcs_pkg.sv
// Shared types, codes and bracket decoders for the bracket match completion scorer.
`timescale 1ns / 1ps

package bmcs_pkg;

   localparam int SCORE_W   = 64;
   localparam int DEPTH_W   = 8;
   localparam int DEPTH_SAT = 255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REFILL,
      ST_FINISH,
      ST_WALK,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      STAT_COMPLETE   = 2'd0,
      STAT_INCOMPLETE = 2'd1,
      STAT_CORRUPTED  = 2'd2,
      STAT_OVERFLOW   = 2'd3
   } status_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
   } bracket_type;

   typedef struct packed {
      logic       clear;
      logic       step;
      logic [1:0] digit;
   } score_ctrl_type;

   function automatic bracket_type decode_opener(logic [7:0] c);
      bracket_type b;
      unique case (c)
         8'h28:   b = '{hit: 1'b1, kind: 2'd0};
         8'h5b:   b = '{hit: 1'b1, kind: 2'd1};
         8'h7b:   b = '{hit: 1'b1, kind: 2'd2};
         8'h3c:   b = '{hit: 1'b1, kind: 2'd3};
         default: b = '{hit: 1'b0, kind: 2'd0};
      endcase
      return b;
   endfunction

   function automatic bracket_type decode_closer(logic [7:0] c);
      bracket_type b;
      unique case (c)
         8'h29:   b = '{hit: 1'b1, kind: 2'd0};
         8'h5d:   b = '{hit: 1'b1, kind: 2'd1};
         8'h7d:   b = '{hit: 1'b1, kind: 2'd2};
         8'h3e:   b = '{hit: 1'b1, kind: 2'd3};
         default: b = '{hit: 1'b0, kind: 2'd0};
      endcase
      return b;
   endfunction

endpackage

### hdl/bmcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bmcs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bmcs_score.sv
// Base-five accumulator for the completion score.
`timescale 1ns / 1ps

module bmcs_score (
   input  logic                          clock,
   input  bmcs_pkg::score_ctrl_type      ctrl,
   output logic [bmcs_pkg::SCORE_W-1:0]  score
);

   import bmcs_pkg::*;

   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] score_in;

   always_comb begin
      score_in = score_ff;
      if (ctrl.clear) begin
         score_in = '0;
      end else if (ctrl.step) begin
         score_in = (score_ff << 2) + score_ff + SCORE_W'(ctrl.digit) + SCORE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
   end

   assign score = score_ff;

endmodule

### hdl/bracket_match_completion_scorer_unit.sv
// Top level of the bracket match completion scorer: sequencer, stack and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | symbol, line_end
//   rsp     | out       | rsp_valid/rsp_stall  | status, completion_score, illegal_type,
//           |           |                      | open_depth
//
// An ordinary byte or a push is handled in the idle state; a pop that leaves one or more
// entries passes through the refill state, since the new top comes back from the stack
// RAM's registered read port. A line end passes through the finish and output states, and
// for an incomplete line also the walk state: the completion walk reads the stack RAM one
// entry a cycle into the score accumulator, then applies the last step after the final read.
// The result waits in an output register; the next line is taken once it is loaded.
// Reset is synchronous and clears control state only; the stack needs no clearing.
`timescale 1ns / 1ps

module bracket_match_completion_scorer_unit #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_symbol,
   input  logic                          req_line_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [bmcs_pkg::SCORE_W-1:0]  rsp_completion_score,
   output logic [1:0]                    rsp_illegal_type,
   output logic [bmcs_pkg::DEPTH_W-1:0]  rsp_open_depth
);

   import bmcs_pkg::*;

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [SPW-1:0]     sp_ff, sp_in;
   logic [SPW-1:0]     left_ff, left_in;
   logic [1:0]         top_ff, top_in;
   logic [1:0]         bad_ff, bad_in;
   logic               corrupt_ff, corrupt_in;
   logic               ovf_ff, ovf_in;
   logic               end_ff, end_in;
   logic               issued_ff, issued_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [SCORE_W-1:0] score_out_ff, score_out_in;
   logic [1:0]         illegal_ff, illegal_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   logic               accept;
   logic               live;
   logic               match;
   logic               sp_full;
   logic               pop_refill;
   logic               slot_free;
   bracket_type        opn;
   bracket_type        cls;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [1:0]         wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [1:0]         rd_data;
   score_ctrl_type     score_ctrl;
   logic [SCORE_W-1:0] score;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign opn        = decode_opener(req_symbol);
   assign cls        = decode_closer(req_symbol);
   assign live       = !corrupt_ff && !ovf_ff;
   assign sp_full    = (sp_ff == SPW'(STACK_DEPTH));
   assign match      = (sp_ff != '0) && (top_ff == cls.kind);
   assign pop_refill = live && !opn.hit && cls.hit && match && (sp_ff >= SPW'(2));
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pop_refill) begin
                  state_in = ST_REFILL;
               end else if (req_line_end) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_REFILL: begin
            state_in = end_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            state_in = (live && (sp_ff != '0)) ? ST_WALK : ST_OUT;
         end
         ST_WALK: begin
            if (left_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sp_in        = sp_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      bad_in       = bad_ff;
      corrupt_in   = corrupt_ff;
      ovf_in       = ovf_ff;
      end_in       = end_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      score_out_in = score_out_ff;
      illegal_in   = illegal_ff;
      depth_in     = depth_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(sp_ff);
      wr_data      = opn.kind;
      rd_en        = 1'b0;
      rd_addr      = AW'(sp_ff - SPW'(2));
      score_ctrl   = '{clear: 1'b0, step: 1'b0, digit: rd_data};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_in = req_line_end;
               if (live) begin
                  if (opn.hit) begin
                     if (sp_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_en  = 1'b1;
                        top_in = opn.kind;
                        sp_in  = sp_ff + SPW'(1);
                     end
                  end else if (cls.hit) begin
                     if (match) begin
                        sp_in = sp_ff - SPW'(1);
                        rd_en = pop_refill;
                     end else begin
                        corrupt_in = 1'b1;
                        bad_in     = cls.kind;
                     end
                  end
               end
            end
         end
         ST_REFILL: begin
            top_in = rd_data;
         end
         ST_FINISH: begin
            score_ctrl.clear = 1'b1;
            left_in          = sp_ff;
            issued_in        = 1'b0;
         end
         ST_WALK: begin
            score_ctrl.step = issued_ff;
            if (left_ff != '0) begin
               rd_en     = 1'b1;
               rd_addr   = AW'(left_ff - SPW'(1));
               left_in   = left_ff - SPW'(1);
               issued_in = 1'b1;
            end else begin
               issued_in = 1'b0;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               score_out_in = score;
               depth_in     = (32'(sp_ff) > 32'(DEPTH_SAT)) ? DEPTH_W'(DEPTH_SAT)
                                                           : DEPTH_W'(sp_ff);
               illegal_in   = 2'd0;
               if (corrupt_ff) begin
                  status_in  = STAT_CORRUPTED;
                  illegal_in = bad_ff;
               end else if (ovf_ff) begin
                  status_in  = STAT_OVERFLOW;
               end else if (sp_ff == '0) begin
                  status_in  = STAT_COMPLETE;
               end else begin
                  status_in  = STAT_INCOMPLETE;
               end
               sp_in      = '0;
               corrupt_in = 1'b0;
               ovf_in     = 1'b0;
               bad_in     = 2'd0;
               end_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         left_ff      <= '0;
         bad_ff       <= 2'd0;
         corrupt_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         end_ff       <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         left_ff      <= left_in;
         bad_ff       <= bad_in;
         corrupt_ff   <= corrupt_in;
         ovf_ff       <= ovf_in;
         end_ff       <= end_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      status_ff    <= status_in;
      score_out_ff <= score_out_in;
      illegal_ff   <= illegal_in;
      depth_ff     <= depth_in;
   end

   bmcs_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmcs_score u_score (
      .clock (clock),
      .ctrl  (score_ctrl),
      .score (score)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_completion_score = score_out_ff;
   assign rsp_illegal_type     = illegal_ff;
   assign rsp_open_depth       = depth_ff;

endmodule

### hdl/bmcs_checker.sv
// Port-level assertions for the bracket match completion scorer, bound to the top level.
`timescale 1ns / 1ps

module bmcs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_status,
   input logic [bmcs_pkg::SCORE_W-1:0]  rsp_completion_score,
   input logic [1:0]                    rsp_illegal_type,
   input logic [bmcs_pkg::DEPTH_W-1:0]  rsp_open_depth
);

   import bmcs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_completion_score) && $stable(rsp_open_depth))
      else $error("stalled rsp transaction changed");

   a_score_only_incomplete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_INCOMPLETE) |-> rsp_completion_score == '0)
      else $error("score set on a line that is not incomplete");

   a_complete_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_COMPLETE) |-> rsp_open_depth == '0)
      else $error("complete line with open entries");

   a_incomplete_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_INCOMPLETE) |-> rsp_open_depth != '0)
      else $error("incomplete line without open entries");

   a_illegal_only_corrupt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_CORRUPTED) |-> rsp_illegal_type == 2'd0)
      else $error("illegal type set on a line that is not corrupted");

endmodule

bind bracket_match_completion_scorer_unit bmcs_checker u_bmcs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_completion_score (rsp_completion_score),
   .rsp_illegal_type     (rsp_illegal_type),
   .rsp_open_depth       (rsp_open_depth)
);
